// ===== hdl/adsh_pkg.sv =====
// ----------------------------------------------------------------------------
// adsh_pkg
// Shared widths, register codes and the divider word type of the
// ambient/diffuse shader.
// ----------------------------------------------------------------------------
package adsh_pkg;

    localparam int APB_DW       = 32;
    localparam int ADDR_W       = 5;
    localparam int COMP_W       = 16;
    localparam int COLOR_W      = 24;
    localparam int CH_W         = 8;
    localparam int PROD_W       = 2 * COMP_W;
    localparam int DOT_W        = PROD_W + 2;
    localparam int FRAC_BITS    = 14;
    localparam int COEF_BITS    = 15;
    localparam int D_W          = 18;
    localparam int MAC_W        = PROD_W + D_W;
    localparam int NUM_W        = 37;
    localparam int DIV_W        = COMP_W + 1;
    localparam int QUOT_W       = 16;
    localparam int REM_W        = DIV_W + QUOT_W;
    localparam int DIV_BPS      = 2;
    localparam int DIV_STAGES   = QUOT_W / DIV_BPS;
    localparam int FRONT_STAGES = 5;
    localparam int CH_PROD_W    = QUOT_W + CH_W;

    localparam logic [CH_W-1:0] CHANNEL_MAX = '1;

    typedef enum logic [2:0] {
        REG_LIGHT_DIR_X    = 3'd0,
        REG_LIGHT_DIR_Y    = 3'd1,
        REG_LIGHT_DIR_Z    = 3'd2,
        REG_AMBIENT_LIGHT  = 3'd3,
        REG_POINT_LIGHT    = 3'd4,
        REG_AMBIENT_COEF   = 3'd5,
        REG_DIFFUSE_COEF   = 3'd6,
        REG_MATERIAL_COLOR = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_word;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic              zero;
    } t_div_res;

endpackage

// ===== hdl/adsh_div.sv =====
// ----------------------------------------------------------------------------
// adsh_div
// Pipelined restoring divider, two quotient bits per stage, quotient
// saturated to all ones and forced to zero on a zero divisor.
// ----------------------------------------------------------------------------
module adsh_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  adsh_pkg::t_div_word  i_word,
    input  logic                 i_adv,
    output logic                 o_adv,
    output logic                 o_vld,
    output adsh_pkg::t_div_res   o_res
);
    import adsh_pkg::*;

    logic [DIV_STAGES-1:0] r_vld;
    logic [DIV_STAGES-1:0] w_en;
    logic [DIV_STAGES-1:0] r_sat;
    logic [DIV_STAGES-1:0] r_zero;
    logic [DIV_STAGES-1:0] w_sat_in;
    logic [DIV_STAGES-1:0] w_zero_in;
    logic [REM_W-1:0]      r_rem   [DIV_STAGES-1];
    logic [REM_W-1:0]      n_rem   [DIV_STAGES-1];
    logic [QUOT_W-1:0]     r_quot  [DIV_STAGES];
    logic [QUOT_W-1:0]     n_quot  [DIV_STAGES];
    logic [DIV_W-1:0]      r_den   [DIV_STAGES];
    logic [REM_W-1:0]      w_rem_in  [DIV_STAGES];
    logic [QUOT_W-1:0]     w_quot_in [DIV_STAGES];
    logic [DIV_W-1:0]      w_den_in  [DIV_STAGES];
    logic                  w_sat0;
    logic                  w_zero0;

    assign w_zero0 = (i_word.den == '0);
    assign w_sat0  = i_word.num >= {{(NUM_W-REM_W){1'b0}}, i_word.den, {QUOT_W{1'b0}}};

    // stage inputs
    always_comb begin
        w_rem_in[0]  = w_sat0 ? '0 : i_word.num[REM_W-1:0];
        w_quot_in[0] = '0;
        w_den_in[0]  = i_word.den;
        w_sat_in[0]  = w_sat0;
        w_zero_in[0] = w_zero0;
        for (int j = 1; j < DIV_STAGES; j++) begin
            w_rem_in[j]  = r_rem[j-1];
            w_quot_in[j] = r_quot[j-1];
            w_den_in[j]  = r_den[j-1];
            w_sat_in[j]  = r_sat[j-1];
            w_zero_in[j] = r_zero[j-1];
        end
    end

    // two restoring steps per stage
    always_comb begin
        logic [REM_W-1:0]  rem;
        logic [QUOT_W-1:0] q;
        logic [REM_W-1:0]  sub;
        int                k;
        rem = '0;
        q   = '0;
        sub = '0;
        k   = 0;
        for (int j = 0; j < DIV_STAGES; j++) begin
            rem = w_rem_in[j];
            q   = w_quot_in[j];
            for (int t = 0; t < DIV_BPS; t++) begin
                k   = QUOT_W - 1 - DIV_BPS * j - t;
                sub = {{(REM_W-DIV_W){1'b0}}, w_den_in[j]} << k;
                if (rem >= sub) begin
                    rem = rem - sub;
                    q   = {q[QUOT_W-2:0], 1'b1};
                end else begin
                    q   = {q[QUOT_W-2:0], 1'b0};
                end
            end
            if (j < DIV_STAGES - 1) begin
                n_rem[j] = rem;
            end
            n_quot[j] = q;
        end
    end

    // bubble-collapsing advance
    always_comb begin
        w_en[DIV_STAGES-1] = !r_vld[DIV_STAGES-1] || i_adv;
        for (int j = DIV_STAGES - 2; j >= 0; j--) begin
            w_en[j] = !r_vld[j] || w_en[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int j = 1; j < DIV_STAGES; j++) begin
                if (w_en[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (w_en[j]) begin
                r_quot[j] <= n_quot[j];
                r_den[j]  <= w_den_in[j];
                r_sat[j]  <= w_sat_in[j];
                r_zero[j] <= w_zero_in[j];
            end
        end
        for (int j = 0; j < DIV_STAGES - 1; j++) begin
            if (w_en[j]) begin
                r_rem[j] <= n_rem[j];
            end
        end
    end

    assign o_adv = w_en[0];
    assign o_vld = r_vld[DIV_STAGES-1];

    always_comb begin
        o_res.zero = r_zero[DIV_STAGES-1];
        priority if (r_zero[DIV_STAGES-1]) begin
            o_res.quot = '0;
        end else if (r_sat[DIV_STAGES-1]) begin
            o_res.quot = '1;
        end else begin
            o_res.quot = r_quot[DIV_STAGES-1];
        end
    end

endmodule

// ===== hdl/ambient_diffuse_shader_unit.sv =====
// ----------------------------------------------------------------------------
// ambient_diffuse_shader_unit
// Lambert diffuse plus ambient shading of one surface normal per word.
// ----------------------------------------------------------------------------
// Takes one Q2.14 surface normal per word and returns the Q1.15 lighting
// intensity, the three shaded color channels and a zero-divisor flag. The
// pipeline accepts one word every cycle while o_in_stall is low and has five
// front stages (light dot product, diffuse term, products and numerator),
// eight divider stages of two quotient bits each and one output stage that
// scales the color. Stages with no valid word do not hold back the input, so
// words keep entering while a result waits at the output. The user must
// write registers over APB only while no word is in flight; no check exists.
module ambient_diffuse_shader_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [adsh_pkg::ADDR_W-1:0]    paddr,
    input  logic [adsh_pkg::APB_DW-1:0]    pwdata,
    output logic [adsh_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [adsh_pkg::COMP_W-1:0] i_normal_x,
    input  logic signed [adsh_pkg::COMP_W-1:0] i_normal_y,
    input  logic signed [adsh_pkg::COMP_W-1:0] i_normal_z,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [adsh_pkg::QUOT_W-1:0]    o_intensity,
    output logic [adsh_pkg::CH_W-1:0]      o_red_out,
    output logic [adsh_pkg::CH_W-1:0]      o_green_out,
    output logic [adsh_pkg::CH_W-1:0]      o_blue_out,
    output logic                           o_zero_divisor
);
    import adsh_pkg::*;

    function automatic logic [CH_W-1:0] sat_channel(input logic [CH_PROD_W-1:0] p);
        return (p[CH_PROD_W-1:COEF_BITS] > {1'b0, CHANNEL_MAX}) ? CHANNEL_MAX
                                                                 : p[COEF_BITS+CH_W-1:COEF_BITS];
    endfunction

    // configuration registers
    logic signed [COMP_W-1:0] r_light_x;
    logic signed [COMP_W-1:0] r_light_y;
    logic signed [COMP_W-1:0] r_light_z;
    logic [COMP_W-1:0]        r_ia;
    logic [COMP_W-1:0]        r_ip;
    logic [COMP_W-1:0]        r_ka;
    logic [COMP_W-1:0]        r_kd;
    logic [COLOR_W-1:0]       r_color;

    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= -16'sd16384;
            r_ia      <= '0;
            r_ip      <= 16'd1;
            r_ka      <= '0;
            r_kd      <= 16'd32768;
            r_color   <= '1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_LIGHT_DIR_X:    r_light_x <= pwdata[COMP_W-1:0];
                REG_LIGHT_DIR_Y:    r_light_y <= pwdata[COMP_W-1:0];
                REG_LIGHT_DIR_Z:    r_light_z <= pwdata[COMP_W-1:0];
                REG_AMBIENT_LIGHT:  r_ia      <= pwdata[COMP_W-1:0];
                REG_POINT_LIGHT:    r_ip      <= pwdata[COMP_W-1:0];
                REG_AMBIENT_COEF:   r_ka      <= pwdata[COMP_W-1:0];
                REG_DIFFUSE_COEF:   r_kd      <= pwdata[COMP_W-1:0];
                REG_MATERIAL_COLOR: r_color   <= pwdata[COLOR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LIGHT_DIR_X:    prdata = APB_DW'(r_light_x);
            REG_LIGHT_DIR_Y:    prdata = APB_DW'(r_light_y);
            REG_LIGHT_DIR_Z:    prdata = APB_DW'(r_light_z);
            REG_AMBIENT_LIGHT:  prdata = APB_DW'(r_ia);
            REG_POINT_LIGHT:    prdata = APB_DW'(r_ip);
            REG_AMBIENT_COEF:   prdata = APB_DW'(r_ka);
            REG_DIFFUSE_COEF:   prdata = APB_DW'(r_kd);
            REG_MATERIAL_COLOR: prdata = APB_DW'(r_color);
        endcase
        prdata[APB_DW-1:COMP_W] = (w_idx == REG_MATERIAL_COLOR)
                                  ? {{(APB_DW-COLOR_W){1'b0}}, r_color[COLOR_W-1:COMP_W]}
                                  : '0;
    end

    // front pipeline
    logic [FRONT_STAGES-1:0]  r_vld;
    logic [FRONT_STAGES-1:0]  w_en;
    logic signed [PROD_W-1:0] r_px;
    logic signed [PROD_W-1:0] r_py;
    logic signed [PROD_W-1:0] r_pz;
    logic signed [DOT_W-1:0]  r_dot;
    logic signed [DOT_W-1:0]  w_neg;
    logic [D_W-1:0]           r_d;
    logic [PROD_W-1:0]        r_ipkd;
    logic [PROD_W-1:0]        r_iaka;
    logic [PROD_W-1:0]        r_iaka3;
    logic [MAC_W-1:0]         r_prod;
    t_div_word                r_word;

    logic     w_div_adv;
    logic     w_div_vld;
    t_div_res w_div_res;
    logic     w_out_en;

    logic               r_out_vld;
    logic [QUOT_W-1:0]  r_intensity;
    logic [CH_W-1:0]    r_red;
    logic [CH_W-1:0]    r_green;
    logic [CH_W-1:0]    r_blue;
    logic               r_zero;

    assign w_neg = -r_dot;

    assign w_out_en = !r_out_vld || !i_out_stall;

    always_comb begin
        w_en[FRONT_STAGES-1] = !r_vld[FRONT_STAGES-1] || w_div_adv;
        for (int j = FRONT_STAGES - 2; j >= 0; j--) begin
            w_en[j] = !r_vld[j] || w_en[j+1];
        end
    end

    assign o_in_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int j = 1; j < FRONT_STAGES; j++) begin
                if (w_en[j]) begin
                    r_vld[j] <= r_vld[j-1];
                end
            end
            if (w_out_en) begin
                r_out_vld <= w_div_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // light dot normal products
        if (w_en[0]) begin
            r_px <= r_light_x * i_normal_x;
            r_py <= r_light_y * i_normal_y;
            r_pz <= r_light_z * i_normal_z;
        end
        if (w_en[1]) begin
            r_dot <= DOT_W'(r_px) + DOT_W'(r_py) + DOT_W'(r_pz);
        end
        // diffuse term and light-coefficient products
        if (w_en[2]) begin
            r_d    <= r_dot[DOT_W-1] ? w_neg[FRAC_BITS+D_W-1:FRAC_BITS] : '0;
            r_ipkd <= r_ip * r_kd;
            r_iaka <= r_ia * r_ka;
        end
        if (w_en[3]) begin
            r_prod  <= r_ipkd * r_d;
            r_iaka3 <= r_iaka;
        end
        // numerator and divisor
        if (w_en[4]) begin
            r_word.num <= NUM_W'(r_iaka3) + NUM_W'(r_prod[MAC_W-1:FRAC_BITS]);
            r_word.den <= DIV_W'(r_ia) + DIV_W'(r_ip);
        end
        // color scaling
        if (w_out_en) begin
            r_intensity <= w_div_res.quot;
            r_zero      <= w_div_res.zero;
            r_red       <= sat_channel(CH_PROD_W'(w_div_res.quot)
                                       * CH_PROD_W'(r_color[3*CH_W-1:2*CH_W]));
            r_green     <= sat_channel(CH_PROD_W'(w_div_res.quot)
                                       * CH_PROD_W'(r_color[2*CH_W-1:CH_W]));
            r_blue      <= sat_channel(CH_PROD_W'(w_div_res.quot)
                                       * CH_PROD_W'(r_color[CH_W-1:0]));
        end
    end

    adsh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[FRONT_STAGES-1]),
        .i_word  (r_word),
        .i_adv   (w_out_en),
        .o_adv   (w_div_adv),
        .o_vld   (w_div_vld),
        .o_res   (w_div_res)
    );

    assign o_out_valid    = r_out_vld;
    assign o_intensity    = r_intensity;
    assign o_red_out      = r_red;
    assign o_green_out    = r_green;
    assign o_blue_out     = r_blue;
    assign o_zero_divisor = r_zero;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ambient/diffuse shader unit.
// ----------------------------------------------------------------------------
// Streams surface normals through the shader with random idle and stall
// bursts on both sides. Between phases the light and material registers are
// programmed over APB and read back. Every output word is compared field by
// field with a Lambert plus ambient shading predictor held in a scoreboard.
module tb;
    import adsh_pkg::*;

    typedef longint unsigned t_u64;

    localparam t_u64 LUM_MAX = (t_u64'(1) << QUOT_W) - 1;

    typedef struct {
        logic [QUOT_W-1:0] intensity;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic              zero_div;
    } t_pixel;

    class shade_scoreboard;
        logic signed [COMP_W-1:0] dir_x, dir_y, dir_z;
        bit [COMP_W-1:0]          ia, ip, ka, kd;
        bit [COLOR_W-1:0]         color;
        t_pixel                   expected_pixels[$];
        int unsigned              errors;

        function new();
            dir_x  = '0;
            dir_y  = '0;
            dir_z  = -16'sd16384;
            ia     = '0;
            ip     = 16'd1;
            ka     = '0;
            kd     = 16'h8000;
            color  = 24'hFFFFFF;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, bit [APB_DW-1:0] v);
            case (idx)
                REG_LIGHT_DIR_X:    dir_x = v[COMP_W-1:0];
                REG_LIGHT_DIR_Y:    dir_y = v[COMP_W-1:0];
                REG_LIGHT_DIR_Z:    dir_z = v[COMP_W-1:0];
                REG_AMBIENT_LIGHT:  ia    = v[COMP_W-1:0];
                REG_POINT_LIGHT:    ip    = v[COMP_W-1:0];
                REG_AMBIENT_COEF:   ka    = v[COMP_W-1:0];
                REG_DIFFUSE_COEF:   kd    = v[COMP_W-1:0];
                REG_MATERIAL_COLOR: color = v[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [CH_W-1:0] scale_channel(t_u64 lum, bit [CH_W-1:0] c);
            t_u64 v;
            v = (lum * c) >> COEF_BITS;
            return (v > CHANNEL_MAX) ? CHANNEL_MAX : v[CH_W-1:0];
        endfunction

        function t_pixel shade_normal(logic signed [COMP_W-1:0] nx,
                                      logic signed [COMP_W-1:0] ny,
                                      logic signed [COMP_W-1:0] nz);
            longint dot;
            t_u64   d, num, divisor, lum;
            t_pixel p;
            dot = longint'(dir_x) * longint'(nx) + longint'(dir_y) * longint'(ny)
                + longint'(dir_z) * longint'(nz);
            d = 0;
            if (dot < 0) begin
                d = t_u64'(-dot) >> FRAC_BITS;
            end
            divisor = t_u64'(ia) + ip;
            lum = 0;
            p.zero_div = (divisor == 0);
            if (divisor != 0) begin
                num = t_u64'(ia) * ka + ((t_u64'(ip) * kd * d) >> FRAC_BITS);
                lum = num / divisor;
                if (lum > LUM_MAX) begin
                    lum = LUM_MAX;
                end
            end
            p.intensity = lum[QUOT_W-1:0];
            p.red       = scale_channel(lum, color[23:16]);
            p.green     = scale_channel(lum, color[15:8]);
            p.blue      = scale_channel(lum, color[7:0]);
            return p;
        endfunction

        function void note_normal(logic signed [COMP_W-1:0] nx,
                                  logic signed [COMP_W-1:0] ny,
                                  logic signed [COMP_W-1:0] nz);
            expected_pixels.push_back(shade_normal(nx, ny, nz));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                $error("output word with nothing expected: intensity %0d", got.intensity);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("intensity", want.intensity, got.intensity);
            compare_field("red_out", want.red, got.red);
            compare_field("green_out", want.green, got.green);
            compare_field("blue_out", want.blue, got.blue);
            compare_field("zero_divisor", want.zero_div, got.zero_div);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [COMP_W-1:0] i_normal_x;
    logic signed [COMP_W-1:0] i_normal_y;
    logic signed [COMP_W-1:0] i_normal_z;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [QUOT_W-1:0]        o_intensity;
    logic [CH_W-1:0]          o_red_out;
    logic [CH_W-1:0]          o_green_out;
    logic [CH_W-1:0]          o_blue_out;
    logic                     o_zero_divisor;

    shade_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              stall_left = 0;

    ambient_diffuse_shader_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_intensity    (o_intensity),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_zero_divisor (o_zero_divisor)
    );

    always #2 i_clk = ~i_clk;

    // result side: check accepted words, then pick the next stall
    always @(posedge i_clk) begin : result_side
        t_pixel got;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            got.intensity = o_intensity;
            got.red       = o_red_out;
            got.green     = o_green_out;
            got.blue      = o_blue_out;
            got.zero_div  = o_zero_divisor;
            sb.check_pixel(got);
        end
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic signed [COMP_W-1:0] rand_comp();
        int v;
        if ($urandom_range(0, 7) == 0) begin
            v = $urandom;
        end else begin
            v = int'($urandom_range(0, 32768)) - 16384;
        end
        return v[COMP_W-1:0];
    endfunction

    function automatic bit [COMP_W-1:0] rand_level();
        bit [COMP_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = '1;
            2:       v = COMP_W'($urandom_range(1, 255));
            default: v = COMP_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_normal(logic signed [COMP_W-1:0] nx,
                               logic signed [COMP_W-1:0] ny,
                               logic signed [COMP_W-1:0] nz);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_normal_x <= nx;
        i_normal_y <= ny;
        i_normal_z <= nz;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_normal(nx, ny, nz);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, bit [APB_DW-1:0] value);
        bit [APB_DW-1:0] mask;
        logic [APB_DW-1:0] readback;
        mask = (idx == REG_MATERIAL_COLOR) ? APB_DW'({COLOR_W{1'b1}})
                                           : APB_DW'({COMP_W{1'b1}});
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        sb.set_reg(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if ((readback & mask) !== (value & mask)) begin
            $error("%s readback: expected %0h, got %0h", idx.name(), value & mask,
                   readback & mask);
            sb.errors++;
        end
    endtask

    task automatic program_shader(bit [COMP_W-1:0] dx, bit [COMP_W-1:0] dy,
                                  bit [COMP_W-1:0] dz, bit [COMP_W-1:0] amb,
                                  bit [COMP_W-1:0] pnt, bit [COMP_W-1:0] amb_k,
                                  bit [COMP_W-1:0] dif_k, bit [COLOR_W-1:0] rgb);
        apb_write(REG_LIGHT_DIR_X, dx);
        apb_write(REG_LIGHT_DIR_Y, dy);
        apb_write(REG_LIGHT_DIR_Z, dz);
        apb_write(REG_AMBIENT_LIGHT, amb);
        apb_write(REG_POINT_LIGHT, pnt);
        apb_write(REG_AMBIENT_COEF, amb_k);
        apb_write(REG_DIFFUSE_COEF, dif_k);
        apb_write(REG_MATERIAL_COLOR, rgb);
    endtask

    initial begin : stimulus
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_in_valid = 1'b0;
        i_normal_x = '0;
        i_normal_y = '0;
        i_normal_z = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting, light along -z
        send_normal(0, 0, 16384);
        send_normal(0, 0, -16384);
        send_normal(0, 0, 0);
        send_normal(16384, -16384, 16384);
        send_normal(32767, 32767, 32767);
        send_normal(-32768, -32768, -32768);

        // full scale light and levels, diffuse term at its largest
        drain();
        program_shader(16'h8000, 16'h8000, 16'h8000, '1, '1, '1, '1, 24'hFFFFFF);
        send_normal(32767, 32767, 32767);
        send_normal(-32768, -32768, -32768);
        send_normal(16384, 0, 0);
        send_normal(0, -16384, 0);

        // no light at all
        drain();
        program_shader(0, 16384, 0, 0, 0, '1, '1, 24'h123456);
        send_normal(0, -16384, 0);
        send_normal(0, 16384, 0);
        send_normal(32767, -32768, 1);

        // ambient only with black material
        drain();
        program_shader(16384, 0, 0, '1, 0, 0, 0, 24'h000000);
        send_normal(-16384, 0, 0);
        send_normal(0, 0, 0);

        drain();
        program_shader(-16384, 0, 0, 1, '1, 16'h8000, '1, 24'h80FF01);
        send_normal(16384, 0, 0);
        send_normal(8192, 0, 0);
        send_normal(-16384, 0, 0);
        send_normal(16384, 16384, -16384);

        // light not normalized
        drain();
        program_shader(16'h7FFF, 16'h7FFF, 0, 100, 200, 16'h4000, 16'h8000, 24'hFF00FF);
        send_normal(-32768, -32768, 0);
        send_normal(1, 1, 1);

        for (int ph = 0; ph < 10; ph++) begin
            drain();
            idle_on = (ph < 8) && ($urandom_range(0, 3) != 0);
            program_shader(rand_comp(), rand_comp(), rand_comp(), rand_level(),
                           rand_level(), rand_level(), rand_level(), COLOR_W'($urandom));
            repeat (200) send_normal(rand_comp(), rand_comp(), rand_comp());
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/adsh_pkg.sv
hdl/adsh_div.sv
hdl/ambient_diffuse_shader_unit.sv
sim/tb.sv
